### rtl/snzoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snzoc_pkg: shared types and constants of the zero-one network checker
// Field widths, function and status codes, register indexes, controller
// state type and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package snzoc_pkg;

  // Parameter defaults
  localparam int WIRES_MAX_DEF  = 20;
  localparam int LAYERS_MAX_DEF = 16;
  localparam int PAIRS_MAX_DEF  = 16;

  // Payload field widths
  localparam int FUNC_W     = 1;
  localparam int IDX_W      = 4;
  localparam int WIRE_W     = 5;
  localparam int ORDER_W    = 64;
  localparam int NIBBLE_W   = 4;
  localparam int STATUS_W   = 2;
  localparam int FAIL_W     = 20;
  localparam int DATA_W     = 32;   // wire vector, one bit per wire index
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_CHECK = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_LOAD_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PASS    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FAIL    = 2'd2;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0]  CFG_WIRE_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  CFG_LAYER_COUNT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] WIRE_COUNT_RST  = 5'd8;
  localparam logic [CFG_DATA_W-1:0] LAYER_COUNT_RST = 5'd0;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_JUDGE,
    ST_RESP
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // write one pair, set load result
    logic start;   // latch check item, begin at input zero
    logic walk;    // step through one comparator slot
    logic fail;    // record failing input
    logic pass;    // record all-sorted result
    logic next;    // move to the next input
    logic post;    // move pending result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic steps_zero;  // no layers applied
    logic walk_done;   // last slot of last step this cycle
    logic sorted;      // current wire vector is sorted
    logic x_last;      // current input is the last one
    logic out_free;    // output register can take a result
  } ctrl_sts_t;

endpackage
`default_nettype wire

### rtl/snzoc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snzoc_in_if: input item channel
// Valid/ready channel carrying one load or check item.
// ----------------------------------------------------------------------------
interface snzoc_in_if;
  import snzoc_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [IDX_W-1:0]    layer_index;
  logic [IDX_W-1:0]    slot_index;
  logic [WIRE_W-1:0]   left_wire;
  logic [WIRE_W-1:0]   right_wire;
  logic [ORDER_W-1:0]  layer_order;

  modport source (
    output valid, func, layer_index, slot_index, left_wire, right_wire, layer_order,
    input  ready
  );

  modport sink (
    input  valid, func, layer_index, slot_index, left_wire, right_wire, layer_order,
    output ready
  );

endinterface
`default_nettype wire

### rtl/snzoc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snzoc_out_if: result channel
// Valid/ready channel carrying one status and failing input per item.
// ----------------------------------------------------------------------------
interface snzoc_out_if;
  import snzoc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FAIL_W-1:0]   failing_input;

  modport source (
    output valid, status, failing_input,
    input  ready
  );

  modport sink (
    input  valid, status, failing_input,
    output ready
  );

endinterface
`default_nettype wire

### rtl/snzoc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snzoc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module snzoc_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/snzoc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snzoc_ctrl: checker sequencer
// Accepts items, walks the comparator slots of each input of a check item,
// judges the result and hands the final status to the output register.
// ----------------------------------------------------------------------------
module snzoc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [snzoc_pkg::FUNC_W-1:0] in_func,
  output logic                         in_ready,
  input  snzoc_pkg::ctrl_sts_t         sts,
  output snzoc_pkg::ctrl_cmd_t         cmd
);
  import snzoc_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = ST_RESP;
          end else begin
            cmd.start = 1'b1;
            state_nxt = sts.steps_zero ? ST_JUDGE : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last comparator read lands this cycle
      ST_DRAIN: begin
        state_nxt = ST_JUDGE;
      end
      ST_JUDGE: begin
        if (!sts.sorted) begin
          cmd.fail  = 1'b1;
          state_nxt = ST_RESP;
        end else if (sts.x_last) begin
          cmd.pass  = 1'b1;
          state_nxt = ST_RESP;
        end else begin
          cmd.next  = 1'b1;
          state_nxt = sts.steps_zero ? ST_JUDGE : ST_WALK;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A result is posted only into a free output register
  a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> sts.out_free)
    else $error("result posted while output register busy");

  // Judging follows a drain, another judge, or a zero-layer start
  a_judge_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_JUDGE) |-> ($past(state_r) == ST_DRAIN || $past(state_r) == ST_JUDGE
                               || $past(state_r) == ST_IDLE))
    else $error("judge entered from unexpected state");

  // An accepted item always leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("item transfer did not start work");

endmodule
`default_nettype wire

### rtl/snzoc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snzoc_dpath: checker datapath
// Configuration registers, pair table and per-layer counts, input counter,
// wire vector with one comparator unit, sortedness test and result registers.
// ----------------------------------------------------------------------------
module snzoc_dpath #(
  parameter int WIRES_MAX  = snzoc_pkg::WIRES_MAX_DEF,
  parameter int LAYERS_MAX = snzoc_pkg::LAYERS_MAX_DEF,
  parameter int PAIRS_MAX  = snzoc_pkg::PAIRS_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  snzoc_pkg::ctrl_cmd_t             cmd,
  output snzoc_pkg::ctrl_sts_t             sts,
  input  logic                             cfg_we,
  input  logic [snzoc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [snzoc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [snzoc_pkg::IDX_W-1:0]      layer_index,
  input  logic [snzoc_pkg::IDX_W-1:0]      slot_index,
  input  logic [snzoc_pkg::WIRE_W-1:0]     left_wire,
  input  logic [snzoc_pkg::WIRE_W-1:0]     right_wire,
  input  logic [snzoc_pkg::ORDER_W-1:0]    layer_order,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [snzoc_pkg::STATUS_W-1:0]   out_status,
  output logic [snzoc_pkg::FAIL_W-1:0]     out_failing_input
);
  import snzoc_pkg::*;

  localparam int Depth  = LAYERS_MAX * PAIRS_MAX;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int LayW   = (LAYERS_MAX > 1) ? $clog2(LAYERS_MAX) : 1;
  localparam int SlotW  = (PAIRS_MAX > 1) ? $clog2(PAIRS_MAX) : 1;
  localparam int CntW   = $clog2(PAIRS_MAX + 1);
  localparam int WidW   = $clog2(WIRES_MAX + 1);
  localparam int StepW  = $clog2(LAYERS_MAX + 1);
  localparam int PairW  = 2 * WIRE_W;

  // Configuration registers
  logic [CFG_DATA_W-1:0] wire_count_r;
  logic [CFG_DATA_W-1:0] layer_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wire_count_r  <= WIRE_COUNT_RST;
      layer_count_r <= LAYER_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIRE_COUNT:  wire_count_r  <= cfg_wdata;
        CFG_LAYER_COUNT: layer_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Load decode: out-of-range layer or slot writes nothing
  logic             load_ok;
  logic             ram_we;
  logic [AddrW-1:0] wr_addr;

  assign load_ok = (int'(layer_index) < LAYERS_MAX) && (int'(slot_index) < PAIRS_MAX);
  assign ram_we  = cmd.load && load_ok;
  assign wr_addr = AddrW'(int'(layer_index) * PAIRS_MAX + int'(slot_index));

  // Per-layer pair counts
  logic [CntW-1:0] pair_cnt_r [LAYERS_MAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAYERS_MAX; i++) begin
        pair_cnt_r[i] <= '0;
      end
    end else if (ram_we) begin
      pair_cnt_r[layer_index[LayW-1:0]] <= CntW'(int'(slot_index) + 1);
    end
  end

  // Check state
  logic [ORDER_W-1:0]   order_r;
  logic [WidW-1:0]      width_r;
  logic [StepW-1:0]     steps_r;
  logic [WIRES_MAX-1:0] x_r;
  logic [WIRES_MAX-1:0] x_inc;
  logic [DATA_W-1:0]    bits_r;
  logic [NIBBLE_W-1:0]  s_r;
  logic [SlotW-1:0]     k_r;
  logic                 apply_r;

  logic [WidW-1:0]      width_clamp;
  logic [StepW-1:0]     steps_clamp;

  assign width_clamp = (int'(wire_count_r) > WIRES_MAX) ? WidW'(WIRES_MAX)
                                                         : WidW'(wire_count_r);
  assign steps_clamp = (int'(layer_count_r) > LAYERS_MAX) ? StepW'(LAYERS_MAX)
                                                           : StepW'(layer_count_r);
  assign x_inc = x_r + 1'b1;

  // Slot walk: current layer, its count, read address
  logic [NIBBLE_W-1:0] cur_layer;
  logic                layer_ok;
  logic [CntW-1:0]     cur_cnt;
  logic                rd_issue;
  logic                slot_last;
  logic                step_last;
  logic [AddrW-1:0]    rd_addr;
  logic [PairW-1:0]    ram_rd;

  assign cur_layer = order_r[{s_r, 2'b00} +: NIBBLE_W];
  assign layer_ok  = int'(cur_layer) < LAYERS_MAX;
  assign cur_cnt   = layer_ok ? pair_cnt_r[cur_layer[LayW-1:0]] : '0;
  assign rd_issue  = int'(k_r) < int'(cur_cnt);
  assign slot_last = (int'(k_r) + 1) >= int'(cur_cnt);
  assign step_last = (int'(s_r) + 1) >= int'(steps_r);
  assign rd_addr   = AddrW'(int'(cur_layer) * PAIRS_MAX + int'(k_r));

  snzoc_ram #(
    .WIDTH (PairW),
    .DEPTH (Depth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata ({left_wire, right_wire}),
    .raddr (rd_addr),
    .rdata (ram_rd)
  );

  // Comparator: move a 1 from the left wire to the right wire
  logic [WIRE_W-1:0] wire_a;
  logic [WIRE_W-1:0] wire_b;
  logic [DATA_W-1:0] bits_apply;

  assign wire_a = ram_rd[PairW-1:WIRE_W];
  assign wire_b = ram_rd[WIRE_W-1:0];

  always_comb begin
    bits_apply = bits_r;
    if (bits_r[wire_a] && !bits_r[wire_b]) begin
      bits_apply[wire_a] = 1'b0;
      bits_apply[wire_b] = 1'b1;
    end
  end

  // Walk counters and read-valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r     <= '0;
      k_r     <= '0;
      apply_r <= 1'b0;
    end else begin
      apply_r <= cmd.walk && rd_issue;
      if (cmd.start || cmd.next) begin
        s_r <= '0;
        k_r <= '0;
      end else if (cmd.walk) begin
        if (slot_last) begin
          k_r <= '0;
          s_r <= s_r + 1'b1;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
    end
  end

  // Input counter and wire vector
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      order_r <= layer_order;
      width_r <= width_clamp;
      steps_r <= steps_clamp;
      x_r     <= '0;
      bits_r  <= '0;
    end else if (cmd.next) begin
      x_r    <= x_inc;
      bits_r <= DATA_W'(x_inc);
    end else if (apply_r) begin
      bits_r <= bits_apply;
    end
  end

  // Sortedness: unmasked zeros must form a run starting at wire 0
  logic [DATA_W-1:0]    judge_mask;
  logic [DATA_W-1:0]    zero_run;
  logic [DATA_W-1:0]    zero_run_inc;
  logic [WIRES_MAX-1:0] x_mask;

  assign judge_mask   = ~({DATA_W{1'b1}} << width_r);
  assign zero_run     = ~bits_r & judge_mask;
  assign zero_run_inc = zero_run + 1'b1;
  assign x_mask       = ~({WIRES_MAX{1'b1}} << width_r);

  // Pending result and output register
  logic [STATUS_W-1:0] res_status_r;
  logic [FAIL_W-1:0]   res_fail_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [FAIL_W-1:0]   out_fail_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status_r <= STATUS_LOAD_OK;
      res_fail_r   <= '0;
    end else if (cmd.pass) begin
      res_status_r <= STATUS_PASS;
      res_fail_r   <= '0;
    end else if (cmd.fail) begin
      res_status_r <= STATUS_FAIL;
      res_fail_r   <= FAIL_W'(x_r);
    end
    if (cmd.post) begin
      out_status_r <= res_status_r;
      out_fail_r   <= res_fail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.post) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_failing_input = out_fail_r;

  // Status to controller
  assign sts.steps_zero = (layer_count_r == '0);
  assign sts.walk_done  = step_last && slot_last;
  assign sts.sorted     = (zero_run & zero_run_inc) == '0;
  assign sts.x_last     = (x_r == x_mask);
  assign sts.out_free   = !out_valid_r || out_ready;

  // Comparator data is applied only in the cycle after a walk issued it
  a_apply_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    apply_r |-> $past(cmd.walk))
    else $error("comparator applied without a walk read");

  // No comparator may still be in flight when an input is judged
  a_no_apply_at_judge: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.next || cmd.pass || cmd.fail) |-> !apply_r)
    else $error("input judged with comparator pending");

  // Failing input field is zero unless the status reports a failure
  a_fail_field_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == STATUS_FAIL) || (out_fail_r == '0))
    else $error("nonzero failing input on non-failing result");

endmodule
`default_nettype wire

### rtl/sorting_network_zero_one_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// At most one comparator per cycle, read through the pair table's read port.
// One item in work at a time. Synchronous active-low reset clears the
// configuration registers, layer counts, walk counters, output valid flag
// and sequencer; the pair table, check state and result registers are not cleared.
// ----------------------------------------------------------------------------
// sorting_network_zero_one_checker: zero-one principle network checker
// Stores a layered comparator network and checks a layer order against
// every 0-1 input, reporting the first unsorted input.
// ----------------------------------------------------------------------------
module sorting_network_zero_one_checker #(
  parameter int WIRES_MAX  = snzoc_pkg::WIRES_MAX_DEF,
  parameter int LAYERS_MAX = snzoc_pkg::LAYERS_MAX_DEF,
  parameter int PAIRS_MAX  = snzoc_pkg::PAIRS_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  snzoc_in_if.sink                         in_chan,
  snzoc_out_if.source                      out_chan,
  input  logic                             cfg_we,
  input  logic [snzoc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [snzoc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import snzoc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  snzoc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_func  (in_chan.func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  snzoc_dpath #(
    .WIRES_MAX  (WIRES_MAX),
    .LAYERS_MAX (LAYERS_MAX),
    .PAIRS_MAX  (PAIRS_MAX)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .layer_index       (in_chan.layer_index),
    .slot_index        (in_chan.slot_index),
    .left_wire         (in_chan.left_wire),
    .right_wire        (in_chan.right_wire),
    .layer_order       (in_chan.layer_order),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_status        (out_chan.status),
    .out_failing_input (out_chan.failing_input)
  );

  assign in_chan.ready = in_ready;

endmodule
`default_nettype wire
